### rtl/assert_macros.svh
// Assertion helpers for the particle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/pesw_pkg.sv
`default_nettype none
package pesw_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int FIELD_DEPTH_DEF = 8;
	localparam int WALL_DEPTH_DEF  = 8;
	localparam int PROD_W = 68;
	localparam int WIDE_W = 70;
	localparam int APB_AW = 5;

	localparam logic [2:0] REQ_STEP  = 3'd0;
	localparam logic [2:0] REQ_IMP   = 3'd1;
	localparam logic [2:0] REQ_FIELD = 3'd2;
	localparam logic [2:0] REQ_WALL  = 3'd3;
	localparam logic [2:0] REQ_POS   = 3'd4;

	localparam logic [2:0] REG_INV_MASS  = 3'd0;
	localparam logic [2:0] REG_RADIUS    = 3'd1;
	localparam logic [2:0] REG_FSCALE    = 3'd2;
	localparam logic [2:0] REG_GRAVITY   = 3'd3;
	localparam logic [2:0] REG_FIELD_CNT = 3'd4;
	localparam logic [2:0] REG_WALL_CNT  = 3'd5;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [19:0]        step_time;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic [2:0]         entry_index;
		logic [30:0]        entry_radius;
		logic [3:0]         wall_kind;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic               wall_hit;
		logic               saturated;
	} out_item_t;

	function automatic logic signed [WIDE_W-1:0] wext(input logic signed [31:0] v);
		return {{(WIDE_W-32){v[31]}}, v};
	endfunction

	function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
		return (v > $signed(70'sh7FFFFFFF)) || (v < -$signed(70'sh80000000));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (v > $signed(70'sh7FFFFFFF))
			r = 32'sh7FFFFFFF;
		else if (v < -$signed(70'sh80000000))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/particle_euler_step_with_walls.sv
// channel | dir | handshake              | payload
// in      | in  | in_valid / in_ready    | in_item  (in_item_t)
// out     | out | out_valid / out_ready  | out_item (out_item_t)
// cfg     | in  | psel/penable/pwrite    | paddr, pwdata, prdata
// One multiplier is shared under a sequencer; it sets the item time.
// in_ready returns as the result is loaded into the output register; a held result stalls FIN.
// arst_n resets control, registers and particle state to defaults; tables stay unwritten.
// A result waits in the output register while the next item is taken.
`default_nettype none
`include "assert_macros.svh"
module particle_euler_step_with_walls
	import pesw_pkg::*;
#(
	parameter int FIELD_DEPTH = FIELD_DEPTH_DEF,
	parameter int WALL_DEPTH  = WALL_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire in_item_t          in_item,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      out_item_t         out_item,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready
);

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam logic [30:0] INV_RST = 31'((ONE + 5) / 10);
	localparam logic [30:0] RAD_RST = 31'(ONE);
	localparam longint GRAV_MAG = (981 * ONE + 50) / 100;
	localparam logic signed [31:0] GRAV_RST = 32'(-GRAV_MAG);
	localparam logic signed [31:0] POSY_RST = 32'(4 * ONE);
	localparam logic [32:0] FRAC_MASK = 33'(ONE - 1);
	localparam int FIW = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
	localparam int WIW = (WALL_DEPTH > 1) ? $clog2(WALL_DEPTH) : 1;
	localparam int FCW = $clog2(FIELD_DEPTH + 1);
	localparam int WCW = $clog2(WALL_DEPTH + 1);
	localparam int ACC_W = 42 + $clog2(FIELD_DEPTH + 1);
	localparam logic [7:0] FD8 = 8'(FIELD_DEPTH);
	localparam logic [7:0] WD8 = 8'(WALL_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE, ST_F_RD, ST_F_SQX, ST_F_SQY, ST_F_SQT, ST_F_CMP, ST_F_FX, ST_F_FY,
		ST_S_FX, ST_S_FY, ST_S_AX, ST_S_AY, ST_S_VX, ST_S_VY, ST_S_PY,
		ST_W_RD, ST_W_CHK, ST_I_X, ST_I_Y, ST_I_W, ST_FIN
	} state_t;

	state_t state_q;

	logic [30:0]        inv_mass_q, radius_q;
	logic [7:0]         fscale_q;
	logic signed [31:0] gravity_q;
	logic [3:0]         fcnt_q, wcnt_q;

	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic signed [31:0] ax_q, ay_q;
	in_item_t           req_q;
	logic               hit_q, sat_q, in_q;
	logic [FCW-1:0]     fi_q;
	logic [WCW-1:0]     wi_q;
	logic [1:0]         kb_q;
	logic [65:0]        acc2_q;
	logic signed [ACC_W-1:0] fx_acc_q, fy_acc_q;
	logic signed [PROD_W-1:0] p_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [31:0] fcx_mem [FIELD_DEPTH];
	logic signed [31:0] fcy_mem [FIELD_DEPTH];
	logic [30:0]        frad_mem [FIELD_DEPTH];
	logic signed [31:0] wx_mem [WALL_DEPTH];
	logic signed [31:0] wy_mem [WALL_DEPTH];
	logic [3:0]         wk_mem [WALL_DEPTH];
	logic signed [31:0] fcx_q, fcy_q, wx_q, wy_q;
	logic [30:0]        frad_q;
	logic [3:0]         wk_q;

	logic               accept, cfg_wr, out_free;
	logic [7:0]         nf8, nw8;
	logic signed [33:0] dx, dy, ma, mb;
	logic [31:0]        rsum;
	logic [32:0]        tsum, tq;
	logic signed [WIDE_W-1:0] fx_w, fy_w, p_sh, base, acc_sum;
	logic signed [PROD_W-1:0] p_shr;
	logic signed [31:0] fx_s, fy_s, sum_s;
	logic               fx_o, fy_o, sum_o;
	logic               is_y, is_plus, w_hit;
	logic signed [31:0] w_coord, w_pt, w_vel;
	logic signed [WIDE_W-1:0] w_tgt;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		unique case (paddr[4:2])
			REG_INV_MASS:  prdata = {1'b0, inv_mass_q};
			REG_RADIUS:    prdata = {1'b0, radius_q};
			REG_FSCALE:    prdata = {24'd0, fscale_q};
			REG_GRAVITY:   prdata = gravity_q;
			REG_FIELD_CNT: prdata = {28'd0, fcnt_q};
			REG_WALL_CNT:  prdata = {28'd0, wcnt_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign nf8 = ({4'd0, fcnt_q} > FD8) ? FD8 : {4'd0, fcnt_q};
	assign nw8 = ({4'd0, wcnt_q} > WD8) ? WD8 : {4'd0, wcnt_q};

	assign dx   = {{2{pos_x_q[31]}}, pos_x_q} - {{2{fcx_q[31]}}, fcx_q};
	assign dy   = {{2{pos_y_q[31]}}, pos_y_q} - {{2{fcy_q[31]}}, fcy_q};
	assign rsum = {1'b0, frad_q} + {1'b0, radius_q};
	assign tsum = {1'b0, rsum} + FRAC_MASK;
	assign tq   = tsum & ~FRAC_MASK;

	assign fx_w = {{(WIDE_W-ACC_W){fx_acc_q[ACC_W-1]}}, fx_acc_q};
	assign fy_w = {{(WIDE_W-ACC_W){fy_acc_q[ACC_W-1]}}, fy_acc_q};
	assign fx_s = sat32(fx_w);
	assign fy_s = sat32(fy_w);
	assign fx_o = ovf32(fx_w);
	assign fy_o = ovf32(fy_w);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_F_SQX: begin ma = dx; mb = dx; end
			ST_F_SQY: begin ma = dy; mb = dy; end
			ST_F_SQT: begin ma = {1'b0, tq}; mb = {1'b0, tq}; end
			ST_F_CMP: begin ma = dx; mb = {26'd0, fscale_q}; end
			ST_F_FX:  begin ma = dy; mb = {26'd0, fscale_q}; end
			ST_S_FX:  begin ma = {{2{fx_s[31]}}, fx_s}; mb = {3'd0, inv_mass_q}; end
			ST_S_FY:  begin ma = {{2{fy_s[31]}}, fy_s}; mb = {3'd0, inv_mass_q}; end
			ST_S_AX:  begin ma = {{2{ax_q[31]}}, ax_q}; mb = {14'd0, req_q.step_time}; end
			ST_S_AY:  begin ma = {{2{ay_q[31]}}, ay_q}; mb = {14'd0, req_q.step_time}; end
			ST_S_VX:  begin ma = {{2{vel_x_q[31]}}, vel_x_q}; mb = {14'd0, req_q.step_time}; end
			ST_S_VY:  begin ma = {{2{vel_y_q[31]}}, vel_y_q}; mb = {14'd0, req_q.step_time}; end
			ST_I_X:   begin ma = {{2{req_q.vec_x[31]}}, req_q.vec_x}; mb = {3'd0, inv_mass_q}; end
			ST_I_Y:   begin ma = {{2{req_q.vec_y[31]}}, req_q.vec_y}; mb = {3'd0, inv_mass_q}; end
			default:  begin ma = '0; mb = '0; end
		endcase
	end

	assign p_shr = p_q >>> FRAC_BITS;
	assign p_sh  = {{(WIDE_W-PROD_W){p_shr[PROD_W-1]}}, p_shr};

	always_comb begin
		unique case (state_q) inside
			ST_S_AX:          base = wext(gravity_q);
			ST_S_AY, ST_I_Y:  base = wext(vel_x_q);
			ST_S_VX, ST_I_W:  base = wext(vel_y_q);
			ST_S_VY:          base = wext(pos_x_q);
			ST_S_PY:          base = wext(pos_y_q);
			default:          base = '0;
		endcase
	end

	assign acc_sum = base + p_sh;
	assign sum_s   = sat32(acc_sum);
	assign sum_o   = ovf32(acc_sum);

	// wall bits: floor, ceiling, left, right
	assign is_y    = !kb_q[1];
	assign is_plus = !kb_q[0];
	assign w_coord = is_y ? pos_y_q : pos_x_q;
	assign w_pt    = is_y ? wy_q : wx_q;
	assign w_vel   = is_y ? vel_y_q : vel_x_q;
	assign w_tgt   = is_plus ? wext(w_pt) + WIDE_W'(radius_q)
	                         : wext(w_pt) - WIDE_W'(radius_q);
	assign w_hit   = wk_q[kb_q] && (is_plus ? (wext(w_coord) < w_tgt)
	                                       : (wext(w_coord) > w_tgt));

	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		if (accept && in_item.req_type == REQ_FIELD &&
		    {5'd0, in_item.entry_index} < FD8) begin
			fcx_mem[FIW'(in_item.entry_index)]  <= in_item.vec_x;
			fcy_mem[FIW'(in_item.entry_index)]  <= in_item.vec_y;
			frad_mem[FIW'(in_item.entry_index)] <= in_item.entry_radius;
		end
		if (accept && in_item.req_type == REQ_WALL &&
		    {5'd0, in_item.entry_index} < WD8) begin
			wx_mem[WIW'(in_item.entry_index)] <= in_item.vec_x;
			wy_mem[WIW'(in_item.entry_index)] <= in_item.vec_y;
			wk_mem[WIW'(in_item.entry_index)] <= in_item.wall_kind;
		end
		if (state_q == ST_F_RD) begin
			fcx_q  <= fcx_mem[fi_q[FIW-1:0]];
			fcy_q  <= fcy_mem[fi_q[FIW-1:0]];
			frad_q <= frad_mem[fi_q[FIW-1:0]];
		end
		if (state_q == ST_W_RD) begin
			wx_q <= wx_mem[wi_q[WIW-1:0]];
			wy_q <= wy_mem[wi_q[WIW-1:0]];
			wk_q <= wk_mem[wi_q[WIW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inv_mass_q  <= INV_RST;
			radius_q    <= RAD_RST;
			fscale_q    <= 8'd10;
			gravity_q   <= GRAV_RST;
			fcnt_q      <= '0;
			wcnt_q      <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= POSY_RST;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			req_q       <= '0;
			hit_q       <= 1'b0;
			sat_q       <= 1'b0;
			in_q        <= 1'b0;
			fi_q        <= '0;
			wi_q        <= '0;
			kb_q        <= '0;
			acc2_q      <= '0;
			fx_acc_q    <= '0;
			fy_acc_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_INV_MASS:  inv_mass_q <= pwdata[30:0];
					REG_RADIUS:    radius_q   <= pwdata[30:0];
					REG_FSCALE:    fscale_q   <= pwdata[7:0];
					REG_GRAVITY:   gravity_q  <= pwdata;
					REG_FIELD_CNT: fcnt_q     <= pwdata[3:0];
					REG_WALL_CNT:  wcnt_q     <= pwdata[3:0];
					default:       ;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q    <= in_item;
						hit_q    <= 1'b0;
						sat_q    <= 1'b0;
						fi_q     <= '0;
						wi_q     <= '0;
						fx_acc_q <= '0;
						fy_acc_q <= '0;
						unique case (in_item.req_type)
							REQ_STEP: state_q <= ST_F_RD;
							REQ_IMP:  state_q <= ST_I_X;
							REQ_POS: begin
								pos_x_q <= in_item.vec_x;
								pos_y_q <= in_item.vec_y;
								state_q <= ST_FIN;
							end
							default:  state_q <= ST_FIN;
						endcase
					end
				end
				ST_F_RD:  state_q <= (8'(fi_q) < nf8) ? ST_F_SQX : ST_S_FX;
				ST_F_SQX: state_q <= ST_F_SQY;
				ST_F_SQY: begin
					acc2_q  <= p_q[65:0];
					state_q <= ST_F_SQT;
				end
				ST_F_SQT: begin
					acc2_q  <= acc2_q + p_q[65:0];
					state_q <= ST_F_CMP;
				end
				ST_F_CMP: begin
					in_q    <= acc2_q < p_q[65:0];
					state_q <= ST_F_FX;
				end
				ST_F_FX: begin
					if (in_q)
						fx_acc_q <= fx_acc_q + p_q[ACC_W-1:0];
					state_q <= ST_F_FY;
				end
				ST_F_FY: begin
					if (in_q)
						fy_acc_q <= fy_acc_q + p_q[ACC_W-1:0];
					fi_q    <= fi_q + 1'b1;
					state_q <= ST_F_RD;
				end
				ST_S_FX: begin
					sat_q   <= sat_q | fx_o;
					state_q <= ST_S_FY;
				end
				ST_S_FY: begin
					ax_q    <= sum_s;
					sat_q   <= sat_q | fy_o | sum_o;
					state_q <= ST_S_AX;
				end
				ST_S_AX: begin
					ay_q    <= sum_s;
					sat_q   <= sat_q | sum_o;
					state_q <= ST_S_AY;
				end
				ST_S_AY: begin
					vel_x_q <= sum_s;
					sat_q   <= sat_q | sum_o;
					state_q <= ST_S_VX;
				end
				ST_S_VX: begin
					vel_y_q <= sum_s;
					sat_q   <= sat_q | sum_o;
					state_q <= ST_S_VY;
				end
				ST_S_VY: begin
					pos_x_q <= sum_s;
					sat_q   <= sat_q | sum_o;
					state_q <= ST_S_PY;
				end
				ST_S_PY: begin
					pos_y_q <= sum_s;
					sat_q   <= sat_q | sum_o;
					state_q <= ST_W_RD;
				end
				ST_W_RD: begin
					kb_q    <= '0;
					state_q <= (8'(wi_q) < nw8) ? ST_W_CHK : ST_FIN;
				end
				ST_W_CHK: begin
					if (w_hit) begin
						hit_q <= 1'b1;
						sat_q <= sat_q | ovf32(w_tgt) | ovf32(-wext(w_vel));
						if (is_y) begin
							pos_y_q <= sat32(w_tgt);
							vel_y_q <= sat32(-wext(w_vel));
						end else begin
							pos_x_q <= sat32(w_tgt);
							vel_x_q <= sat32(-wext(w_vel));
						end
					end
					kb_q <= kb_q + 1'b1;
					if (kb_q == 2'd3) begin
						wi_q    <= wi_q + 1'b1;
						state_q <= ST_W_RD;
					end
				end
				ST_I_X: state_q <= ST_I_Y;
				ST_I_Y: begin
					vel_x_q <= sum_s;
					sat_q   <= sat_q | sum_o;
					state_q <= ST_I_W;
				end
				ST_I_W: begin
					vel_y_q <= sum_s;
					sat_q   <= sat_q | sum_o;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q.pos_x     <= pos_x_q;
						out_q.pos_y     <= pos_y_q;
						out_q.vel_x     <= vel_x_q;
						out_q.vel_y     <= vel_y_q;
						out_q.wall_hit  <= hit_q;
						out_q.saturated <= sat_q;
						out_valid_q     <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_accept_leaves_idle, clk, arst_n, accept |=> state_q != ST_IDLE)
	`ASSERT_CLK(a_fin_loads_out, clk, arst_n, (state_q == ST_FIN && out_free) |=> out_valid_q)
	`ASSERT_CLK(a_field_in_range, clk, arst_n, (state_q == ST_F_SQX) |-> (8'(fi_q) < nf8))
	`ASSERT_NEVER(a_no_hit_on_impulse, clk, arst_n, state_q == ST_I_W && hit_q)

endmodule
`default_nettype wire
